/* src/mbe_pkg.sv */
// Shared types and constants for the Mandelbrot escape-time evaluator.
// Holds register formats, reset values, register indexes and state types.
// No dependencies.
package mbe_pkg;

  localparam int unsigned RADIUS_FRAC   = 28;
  localparam int unsigned RADIUS_W      = 30;
  localparam int unsigned WORK_FRAC_MAX = 28;
  localparam int unsigned ITER_W        = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;

  localparam logic [ITER_W-1:0]   MAX_ITER_RESET = 16'd256;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 30'h2000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER = 2'd0,
    CFG_RADIUS   = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_Y2,
    FR_Q,
    FR_T,
    FR_BULB,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ITER,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic              in_set;
    logic [ITER_W-1:0] count;
  } result_t;

endpackage

/* src/mandelbrot_escape_time.sv */
// Mandelbrot escape-time evaluator, top level with configuration registers.
// Instantiates mbe_front, mbe_queue and mbe_back; uses mbe_pkg.
//
// Push a point c (two signed fixed-point coordinates with FRACTION_BITS
// fraction bits) while full is low; pop one result per point, in order, while
// empty is low. A result gives in_set and escape_count: points inside the main
// cardioid or the period-2 bulb, and points that survive max_iterations, come
// back as in-set with count 0; others report the first iteration whose
// |z|^2 exceeds R^2. The classifier takes one point at a time (four steps on
// one shared multiplier plus the hand-off), and runs ahead of the iterator
// through a 2-entry queue. The iterator does one z = z^2 + c step per cycle on
// three parallel multipliers, and the iterator loop sets the sustained rate.
// Results wait in an output register, so new points keep flowing while a
// result is not yet popped.
// Registers: index 0 is max_iterations (16 bits, reset 256), index 1 is the
// escape radius in unsigned Q2.28 (30 bits, reset 2.0); writes to other
// indexes are dropped. Write them only while the block is idle. cfg_ready is
// always high. There is no clearing pass after reset.
module mandelbrot_escape_time #(
  parameter int unsigned COORD_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 28
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [COORD_BITS-1:0]      c_real_i,
  input  logic signed [COORD_BITS-1:0]      c_imag_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              in_set_o,
  output logic [mbe_pkg::ITER_W-1:0]        escape_count_o,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import mbe_pkg::*;

  localparam int unsigned WORK_FRAC = (FRACTION_BITS < WORK_FRAC_MAX) ?
                                      FRACTION_BITS : WORK_FRAC_MAX;
  localparam int unsigned RAD_SHIFT = RADIUS_FRAC - WORK_FRAC;
  localparam int unsigned RAD_W     = WORK_FRAC + 2;
  localparam int unsigned Z_W       = WORK_FRAC + 6;
  localparam int unsigned QD_W      = 2 * Z_W + 2;
  localparam int unsigned Q_DEPTH   = 2;

  // Configuration registers.
  logic [ITER_W-1:0]   max_iter_q, max_iter_d;
  logic [RADIUS_W-1:0] radius_q, radius_d;
  logic [RAD_W-1:0]    radius_w;
  logic [2*RAD_W-1:0]  radius_sq_q;

  // Classifier to queue.
  logic                  fq_push, fq_full;
  logic                  fq_hit, fq_esc0;
  logic signed [Z_W-1:0] fq_cr, fq_ci;
  logic [QD_W-1:0]       fq_data;

  // Queue to iterator.
  logic                  qb_pop, qb_empty;
  logic [QD_W-1:0]       qb_data;
  logic                  qb_hit, qb_esc0;
  logic signed [Z_W-1:0] qb_cr, qb_ci;

  result_t result;

  // Accept a write every cycle; drop indexes beyond the list.
  assign cfg_ready = 1'b1;

  always_comb begin
    max_iter_d = max_iter_q;
    radius_d   = radius_q;
    if (cfg_valid) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_ITER: max_iter_d = cfg_data_i[ITER_W-1:0];
        CFG_RADIUS:   radius_d   = cfg_data_i[RADIUS_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MAX_ITER_RESET;
      radius_q   <= RADIUS_RESET;
    end else begin
      max_iter_q <= max_iter_d;
      radius_q   <= radius_d;
    end
  end

  // Floor the radius to the working format; the square is registered, well
  // before any point reaches the escape test.
  assign radius_w = radius_q[RADIUS_W-1:RAD_SHIFT];

  always_ff @(posedge clk_i) begin
    radius_sq_q <= radius_w * radius_w;
  end

  mbe_front #(
    .COORD_BITS    (COORD_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .c_real_i  (c_real_i),
    .c_imag_i  (c_imag_i),
    .radius_i  (radius_w),
    .q_push_o  (fq_push),
    .q_full_i  (fq_full),
    .q_hit_o   (fq_hit),
    .q_esc0_o  (fq_esc0),
    .q_cr_o    (fq_cr),
    .q_ci_o    (fq_ci)
  );

  assign fq_data = {fq_hit, fq_esc0, fq_cr, fq_ci};

  mbe_queue #(
    .DATA_W (QD_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .data_i  (fq_data),
    .pop_i   (qb_pop),
    .empty_o (qb_empty),
    .data_o  (qb_data)
  );

  assign qb_hit  = qb_data[QD_W-1];
  assign qb_esc0 = qb_data[QD_W-2];
  assign qb_cr   = $signed(qb_data[2*Z_W-1:Z_W]);
  assign qb_ci   = $signed(qb_data[Z_W-1:0]);

  mbe_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (qb_empty),
    .q_pop_o     (qb_pop),
    .q_hit_i     (qb_hit),
    .q_esc0_i    (qb_esc0),
    .q_cr_i      (qb_cr),
    .q_ci_i      (qb_ci),
    .max_iter_i  (max_iter_q),
    .radius_i    (radius_w),
    .radius_sq_i (radius_sq_q),
    .out_empty_o (empty),
    .out_pop_i   (pop),
    .result_o    (result)
  );

  assign in_set_o       = result.in_set;
  assign escape_count_o = result.count;

endmodule

/* src/mbe_queue.sv */
// Short first-word-fall-through queue between the classifier and the iterator.
// Generic payload width; depends on nothing else.
module mbe_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [DATA_W-1:0] data_i,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

/* src/mbe_front.sv */
// Classifier: takes a point, floors it to the working format, runs the
// cardioid and bulb tests on one shared multiplier. Uses mbe_pkg.
module mbe_front #(
  parameter int unsigned COORD_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 28,
  localparam int unsigned WORK_FRAC = (FRACTION_BITS < mbe_pkg::WORK_FRAC_MAX) ?
                                      FRACTION_BITS : mbe_pkg::WORK_FRAC_MAX,
  localparam int unsigned RAD_W = WORK_FRAC + 2,
  localparam int unsigned Z_W   = WORK_FRAC + 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [COORD_BITS-1:0] c_real_i,
  input  logic signed [COORD_BITS-1:0] c_imag_i,
  input  logic        [RAD_W-1:0]      radius_i,
  output logic                         q_push_o,
  input  logic                         q_full_i,
  output logic                         q_hit_o,
  output logic                         q_esc0_o,
  output logic signed [Z_W-1:0]        q_cr_o,
  output logic signed [Z_W-1:0]        q_ci_o
);

  import mbe_pkg::*;

  localparam int unsigned IN_SHIFT = FRACTION_BITS - WORK_FRAC;
  localparam int unsigned C_W      = COORD_BITS - IN_SHIFT;
  localparam int unsigned MAG_W    = ((C_W > RAD_W) ? C_W : RAD_W) + 1;
  localparam int unsigned M_W      = WORK_FRAC + 4;
  localparam int unsigned P_W      = 2 * M_W;

  localparam logic [MAG_W-1:0]        ONE_MAG   = MAG_W'(1) << WORK_FRAC;
  localparam logic [MAG_W-1:0]        TWO_MAG   = MAG_W'(2) << WORK_FRAC;
  localparam logic signed [M_W-1:0]   QUARTER_M = M_W'(1) << (WORK_FRAC - 2);
  localparam logic signed [M_W-1:0]   ONE_M     = M_W'(1) << WORK_FRAC;
  localparam logic signed [P_W-1:0]   BULB_LIM  = P_W'(1) << (2 * WORK_FRAC - 4);

  fr_state_e state_q, state_d;

  logic signed [C_W-1:0]   cr_full, ci_full;
  logic signed [MAG_W-1:0] cr_sx, ci_sx;
  logic        [MAG_W-1:0] cr_mag, ci_mag, rad_ext;
  logic                    accept;

  logic signed [Z_W-1:0] cr_z_q, ci_z_q;
  logic                  near1_q, near2_q, esc0_q;
  logic                  hit_q, hit_d;
  logic signed [P_W-1:0] y2_q, y2_d;
  logic signed [M_W-1:0] qf_q, qf_d;

  logic signed [M_W-1:0] cr_m, ci_m, x_m, p_m, qfx_m;
  logic signed [M_W-1:0] mul_a, mul_b;
  logic signed [P_W-1:0] prod, sum;

  // Floor the inputs to the working format and take magnitudes.
  assign cr_full = $signed(c_real_i[COORD_BITS-1:IN_SHIFT]);
  assign ci_full = $signed(c_imag_i[COORD_BITS-1:IN_SHIFT]);
  assign cr_sx   = MAG_W'(cr_full);
  assign ci_sx   = MAG_W'(ci_full);
  assign cr_mag  = cr_sx[MAG_W-1] ? -cr_sx : cr_sx;
  assign ci_mag  = ci_sx[MAG_W-1] ? -ci_sx : ci_sx;
  assign rad_ext = MAG_W'(radius_i);

  assign cr_m  = M_W'(cr_z_q);
  assign ci_m  = M_W'(ci_z_q);
  assign x_m   = cr_m - QUARTER_M;
  assign p_m   = cr_m + ONE_M;
  assign qfx_m = qf_q + x_m;
  assign prod  = mul_a * mul_b;
  assign sum   = prod + y2_q;

  assign full_o   = (state_q != FR_IDLE);
  assign accept   = push_i && !full_o;
  assign q_hit_o  = hit_q;
  assign q_esc0_o = esc0_q;
  assign q_cr_o   = cr_z_q;
  assign q_ci_o   = ci_z_q;

  always_comb begin
    state_d  = state_q;
    hit_d    = hit_q;
    y2_d     = y2_q;
    qf_d     = qf_q;
    mul_a    = ci_m;
    mul_b    = ci_m;
    q_push_o = 1'b0;
    case (state_q)
      FR_IDLE: begin
        if (push_i) begin
          hit_d   = 1'b0;
          state_d = FR_Y2;
        end
      end
      FR_Y2: begin
        y2_d    = prod;
        state_d = FR_Q;
      end
      FR_Q: begin
        mul_a   = x_m;
        mul_b   = x_m;
        qf_d    = M_W'(sum >>> WORK_FRAC);
        state_d = FR_T;
      end
      FR_T: begin
        mul_a   = qf_q;
        mul_b   = qfx_m;
        hit_d   = near1_q && ((prod <<< 2) < y2_q);
        state_d = FR_BULB;
      end
      FR_BULB: begin
        mul_a   = p_m;
        mul_b   = p_m;
        hit_d   = hit_q || (near2_q && (sum < BULB_LIM));
        state_d = FR_PUSH;
      end
      FR_PUSH: begin
        q_push_o = !q_full_i;
        if (!q_full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: begin
        state_d = FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
    y2_q  <= y2_d;
    qf_q  <= qf_d;
    if (accept) begin
      cr_z_q  <= Z_W'(cr_full);
      ci_z_q  <= Z_W'(ci_full);
      near1_q <= (cr_mag < ONE_MAG) && (ci_mag < ONE_MAG);
      near2_q <= (cr_mag < TWO_MAG) && (ci_mag < TWO_MAG);
      esc0_q  <= (cr_mag > rad_ext) || (ci_mag > rad_ext);
    end
  end

endmodule

/* src/mbe_back.sv */
// Iterator: runs z = z^2 + c one iteration per cycle and holds the result
// in an output register until it is popped. Uses mbe_pkg.
module mbe_back #(
  parameter int unsigned FRACTION_BITS = 28,
  localparam int unsigned WORK_FRAC = (FRACTION_BITS < mbe_pkg::WORK_FRAC_MAX) ?
                                      FRACTION_BITS : mbe_pkg::WORK_FRAC_MAX,
  localparam int unsigned RAD_W = WORK_FRAC + 2,
  localparam int unsigned Z_W   = WORK_FRAC + 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  output logic                        q_pop_o,
  input  logic                        q_hit_i,
  input  logic                        q_esc0_i,
  input  logic signed [Z_W-1:0]       q_cr_i,
  input  logic signed [Z_W-1:0]       q_ci_i,
  input  logic [mbe_pkg::ITER_W-1:0]  max_iter_i,
  input  logic [RAD_W-1:0]            radius_i,
  input  logic [2*RAD_W-1:0]          radius_sq_i,
  output logic                        out_empty_o,
  input  logic                        out_pop_i,
  output mbe_pkg::result_t            result_o
);

  import mbe_pkg::*;

  localparam int unsigned S_W    = 2 * Z_W;
  localparam int unsigned CMP_W  = ((S_W + 1) > (2 * RAD_W)) ? (S_W + 1) : (2 * RAD_W);
  localparam int unsigned MAGZ_W = ((Z_W + 1) > RAD_W) ? (Z_W + 1) : RAD_W;

  bk_state_e state_q, state_d;

  logic signed [Z_W-1:0]  zr_q, zr_d, zi_q, zi_d;
  logic signed [Z_W-1:0]  cr_q, cr_d, ci_q, ci_d;
  logic                   esc0_q, esc0_d;
  logic [ITER_W-1:0]      iter_q, iter_d;
  result_t                res_q, res_d;
  result_t                out_res_q, out_res_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;

  logic signed [S_W-1:0]  sq_r, sq_i, zrzi, diff;
  logic        [S_W-1:0]  sq_r_u, sq_i_u;
  logic signed [Z_W:0]    zr_e, zi_e;
  logic        [Z_W:0]    zr_mag, zi_mag;
  logic        [CMP_W-1:0] mag_sum;
  logic                   escape;
  logic signed [Z_W-1:0]  zr_next, zi_next;

  assign sq_r   = zr_q * zr_q;
  assign sq_i   = zi_q * zi_q;
  assign zrzi   = zr_q * zi_q;
  assign sq_r_u = sq_r;
  assign sq_i_u = sq_i;
  assign zr_e   = (Z_W + 1)'(zr_q);
  assign zi_e   = (Z_W + 1)'(zi_q);
  assign zr_mag = zr_e[Z_W] ? -zr_e : zr_e;
  assign zi_mag = zi_e[Z_W] ? -zi_e : zi_e;
  assign mag_sum = CMP_W'(sq_r_u) + CMP_W'(sq_i_u);

  // Far start points escape on the first test from the classifier's flag.
  assign escape = esc0_q ||
                  (MAGZ_W'(zr_mag) > MAGZ_W'(radius_i)) ||
                  (MAGZ_W'(zi_mag) > MAGZ_W'(radius_i)) ||
                  (mag_sum > CMP_W'(radius_sq_i));

  assign diff    = sq_r - sq_i;
  assign zr_next = Z_W'(diff >>> WORK_FRAC) + cr_q;
  assign zi_next = Z_W'(zrzi >>> (WORK_FRAC - 1)) + ci_q;

  assign out_empty_o = !out_valid_q;
  assign result_o    = out_res_q;

  always_comb begin
    state_d  = state_q;
    zr_d     = zr_q;
    zi_d     = zi_q;
    cr_d     = cr_q;
    ci_d     = ci_q;
    esc0_d   = esc0_q;
    iter_d   = iter_q;
    res_d    = res_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          zr_d    = q_cr_i;
          zi_d    = q_ci_i;
          cr_d    = q_cr_i;
          ci_d    = q_ci_i;
          esc0_d  = q_esc0_i;
          iter_d  = '0;
          if (q_hit_i) begin
            res_d   = '{in_set: 1'b1, count: '0};
            state_d = BK_DONE;
          end else begin
            state_d = BK_ITER;
          end
        end
      end
      BK_ITER: begin
        if (iter_q == max_iter_i) begin
          res_d   = '{in_set: 1'b1, count: '0};
          state_d = BK_DONE;
        end else if (escape) begin
          res_d   = '{in_set: 1'b0, count: iter_q};
          state_d = BK_DONE;
        end else begin
          zr_d   = zr_next;
          zi_d   = zi_next;
          iter_d = ITER_W'(iter_q + 1'b1);
        end
      end
      BK_DONE: begin
        if (!out_valid_q || out_pop_i) begin
          out_load = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_pop_i;
    out_res_d   = out_res_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_res_d   = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q      <= zr_d;
    zi_q      <= zi_d;
    cr_q      <= cr_d;
    ci_q      <= ci_d;
    esc0_q    <= esc0_d;
    iter_q    <= iter_d;
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  a_in_set_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.in_set) |-> (out_res_q.count == '0))
    else $error("in-set result with nonzero escape count");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ITER) |-> (iter_q <= max_iter_i))
    else $error("iteration count passed the limit");

  a_done_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DONE && !out_valid_q) |=> (out_valid_q && state_q == BK_IDLE))
    else $error("finished result not moved to output register");

endmodule

/* tb/sv/mbe_scoreboard_pkg.sv */
// Scoreboard for the Mandelbrot escape-time evaluator testbench.
// Holds the escape-time predictor and the queue of expected results.
// Depends on mbe_pkg for the register indexes, reset values and result type.
package mbe_scoreboard_pkg;

  import mbe_pkg::*;

  // working fraction bits at the default coordinate format (Q4.28)
  localparam int WORK_FRAC = 28;

  class escape_scoreboard;

    logic [ITER_W-1:0]   iter_limit;
    logic [RADIUS_W-1:0] radius;
    result_t             pending_results[$];
    int                  errors;
    int                  points;
    int                  checked;
    int                  bounded;
    int                  escaped;

    function new();
      iter_limit = MAX_ITER_RESET;
      radius     = RADIUS_RESET;
      errors     = 0;
      points     = 0;
      checked    = 0;
      bounded    = 0;
      escaped    = 0;
    endfunction

    // Mirror a register write; unknown indexes are dropped.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_ITER: iter_limit = data[ITER_W-1:0];
        CFG_RADIUS:   radius = data[RADIUS_W-1:0];
        default: ;
      endcase
    endfunction

    // Main cardioid and period-2 bulb, each tried only inside its bounding box.
    function bit in_shortcut(longint cr, longint ci);
      longint one, x, y2, q, qf, t, p, s;
      one = 64'sd1 <<< WORK_FRAC;
      if (cr > -one && cr < one && ci > -one && ci < one) begin
        x  = cr - (one >>> 2);
        y2 = ci * ci;
        q  = x * x + y2;
        qf = q >>> WORK_FRAC;
        t  = qf * (qf + x);
        if (4 * t < y2) return 1'b1;
      end
      if (cr > -2 * one && cr < 2 * one && ci > -2 * one && ci < 2 * one) begin
        p = cr + one;
        s = p * p + ci * ci;
        if (s < (64'sd1 <<< (2 * WORK_FRAC - 4))) return 1'b1;
      end
      return 1'b0;
    endfunction

    function result_t escape_time(longint cr, longint ci);
      result_t             res;
      longint              zr, zi, sq_diff, cross_term;
      longint unsigned     r, r2, ar, ai;
      r   = radius;
      r2  = r * r;
      res.in_set = 1'b1;
      res.count  = '0;
      if (in_shortcut(cr, ci)) return res;
      zr = cr;
      zi = ci;
      for (int unsigned i = 0; i < iter_limit; i++) begin
        ar = (zr < 0) ? -zr : zr;
        ai = (zi < 0) ? -zi : zi;
        // the magnitude checks come first so the squares cannot overflow
        if (ar > r || ai > r || ar * ar + ai * ai > r2) begin
          res.in_set = 1'b0;
          res.count  = i[ITER_W-1:0];
          return res;
        end
        sq_diff    = zr * zr - zi * zi;
        cross_term = 2 * (zr * zi);
        zr = (sq_diff >>> WORK_FRAC) + cr;
        zi = (cross_term >>> WORK_FRAC) + ci;
      end
      return res;
    endfunction

    function void note_point(logic signed [31:0] re, logic signed [31:0] im);
      pending_results.push_back(escape_time(longint'(re), longint'(im)));
      points++;
    endfunction

    function void check_result(logic in_set, logic [ITER_W-1:0] count);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: in_set %0b escape_count %0d", in_set, count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (in_set !== want.in_set) begin
        $error("in_set mismatch: expected %0b, actual %0b", want.in_set, in_set);
        errors++;
      end
      if (count !== want.count) begin
        $error("escape_count mismatch: expected %0d, actual %0d", want.count, count);
        errors++;
      end
      if (want.in_set) bounded++;
      else escaped++;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

  endclass

endpackage

/* tb/sv/tb_top.sv */
// Top-level testbench for mandelbrot_escape_time.
// Drives points and register writes, checks every result against a predictor;
// depends on mbe_pkg, mbe_scoreboard_pkg and the RTL of the evaluator.
module tb_top;

  import mbe_pkg::*;
  import mbe_scoreboard_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int COORD_BITS = 32;

  // Q4.28 reference values
  localparam logic signed [COORD_BITS-1:0] Q_ONE     = 32'sd268435456;
  localparam logic signed [COORD_BITS-1:0] Q_QUARTER = 32'sd67108864;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_BITS-1:0] Q_ULP     = 32'sd1;

  // register limits
  localparam logic [CFG_DATA_W-1:0] LIMIT_ZERO   = 32'd0;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RESET  = 32'd256;
  localparam logic [CFG_DATA_W-1:0] LIMIT_MAX    = 32'd65535;
  localparam logic [CFG_DATA_W-1:0] RADIUS_ZERO  = 32'd0;
  localparam logic [CFG_DATA_W-1:0] RADIUS_TWO   = 32'h2000_0000;
  localparam logic [CFG_DATA_W-1:0] RADIUS_ONE   = 32'h1000_0000;
  localparam logic [CFG_DATA_W-1:0] RADIUS_UPPER = 32'h3FFF_FFFF;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] re;
    logic signed [COORD_BITS-1:0] im;
  } point_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         push;
  logic                         full;
  logic signed [COORD_BITS-1:0] c_real;
  logic signed [COORD_BITS-1:0] c_imag;
  logic                         empty;
  logic                         pop;
  logic                         in_set_o;
  logic [ITER_W-1:0]            escape_count_o;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  escape_scoreboard escapes = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;   // receiver hold-off, counted down by the receiver
  int reg_writes     = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  mandelbrot_escape_time uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .c_real_i       (c_real),
    .c_imag_i       (c_imag),
    .empty          (empty),
    .pop            (pop),
    .in_set_o       (in_set_o),
    .escape_count_o (escape_count_o),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Offer one point, idling first at the configured rate; return once the
  // transaction is accepted. Leave push high so back-to-back points flow.
  task automatic send_point(logic signed [COORD_BITS-1:0] re, logic signed [COORD_BITS-1:0] im);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push   <= 1'b1;
    c_real <= re;
    c_imag <= im;
    do @(posedge clk_i); while (full);
    escapes.note_point(re, im);
  endtask

  task automatic stop_push();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // Write one register; only call this while nothing is in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    escapes.write_reg(idx, data);
    reg_writes++;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every expected result, then let the pipeline idle before returning.
  task automatic settle();
    while (escapes.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_pace(int send_idle, int recv_stall);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
  endtask

  // Mix: mostly the region around the set, some points hugging the cusp
  // between cardioid and bulb (long escapes), some anywhere in the full range.
  function automatic point_t random_point();
    point_t      p;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      p.re = $urandom;
      p.im = $urandom;
    end else if (pick < 30) begin
      p.re = -3 * Q_QUARTER + int'($urandom_range(1 << 20)) - (1 << 19);
      p.im = int'($urandom_range(1 << 24)) - (1 << 23);
    end else begin
      p.re = int'($urandom_range(939524096)) - 671088640;   // -2.5 .. 1.0
      p.im = int'($urandom_range(805306368)) - 402653184;   // -1.5 .. 1.5
    end
    return p;
  endfunction

  task automatic send_random(int count);
    point_t p;
    repeat (count) begin
      p = random_point();
      send_point(p.re, p.im);
    end
    stop_push();
  endtask

  // Receiver: stall at random, or hold off entirely while hold_left runs down.
  // Sample the result at the rising edge where pop meets a non-empty queue.
  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (pop && !empty) escapes.check_result(in_set_o, escape_count_o);
    end
  end

  initial begin
    rst_ni    = 1'b0;
    push      = 1'b0;
    c_real    = '0;
    c_imag    = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_ITER;
    cfg_data  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed points at reset settings: shortcut regions, their edges and
    // cusps, points that never escape, and the coordinate extremes.
    set_pace(0, 0);
    send_point('0, '0);                          // cardioid center
    send_point(-Q_ONE, '0);                      // bulb center, cardioid box skipped
    send_point(Q_QUARTER, '0);                   // cardioid cusp, bounded
    send_point(-3 * Q_QUARTER, '0);              // cardioid-bulb junction
    send_point(-2 * Q_ONE, '0);                  // tip of the set, stays at 2
    send_point('0, Q_ONE);                       // i, periodic orbit
    send_point(-5 * Q_QUARTER, '0);              // edge of the bulb
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX);
    send_point(COORD_MAX, COORD_MIN);
    send_point(-Q_ULP, -Q_ULP);
    send_point(Q_ONE * 3 / 10, '0);              // slow escape past the cusp
    send_point(Q_ONE - Q_ULP, Q_ONE - Q_ULP);    // corner of the cardioid box
    stop_push();
    settle();

    // Hold off the receiver long enough for the block to back up and stall
    // its input, while the sender keeps offering points.
    hold_left = 300;
    send_random(40);
    settle();

    // Back-to-back traffic, no idling on either side.
    send_random(300);
    settle();

    write_reg(CFG_MAX_ITER, CFG_DATA_W'($urandom_range(300, 16)));
    set_pace(74, 0);
    send_random(400);
    settle();

    write_reg(CFG_MAX_ITER, 32'd1000);
    write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(RADIUS_TWO, RADIUS_ONE)));
    set_pace(0, 74);
    send_random(400);
    settle();

    write_reg(CFG_MAX_ITER, 32'd64);
    write_reg(CFG_RADIUS, RADIUS_UPPER);
    set_pace(36, 36);
    send_random(400);
    settle();

    // Zero limit: anything outside the shortcut regions comes back in-set.
    set_pace(0, 0);
    write_reg(CFG_MAX_ITER, LIMIT_ZERO);
    write_reg(CFG_RADIUS, RADIUS_TWO);
    send_point(Q_QUARTER, '0);
    send_point(3 * Q_ONE, '0);
    stop_push();
    settle();

    // Zero radius: any nonzero z escapes on the first test.
    write_reg(CFG_MAX_ITER, LIMIT_RESET);
    write_reg(CFG_RADIUS, RADIUS_ZERO);
    send_point('0, '0);
    send_point(Q_ONE / 2, Q_ONE / 2);
    stop_push();
    settle();

    // Writes to unused indexes must leave both registers alone.
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    send_point(Q_QUARTER, '0);
    stop_push();
    settle();

    // Largest limit and radius; one bounded point runs the full limit.
    write_reg(CFG_MAX_ITER, LIMIT_MAX);
    write_reg(CFG_RADIUS, RADIUS_UPPER);
    send_point(Q_QUARTER, '0);
    send_point(COORD_MIN, COORD_MIN);
    send_point(Q_ONE / 10 * 19, '0);
    stop_push();
    settle();

    // Random settings, limit up to 511 and radius up to 2.0, back-to-back traffic.
    write_reg(CFG_MAX_ITER, CFG_DATA_W'($urandom_range(511)));
    write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(RADIUS_TWO)));
    send_random(300);
    settle();

    $display("Checked %0d results for %0d points: %0d in the set, %0d escaped.",
             escapes.checked, escapes.points, escapes.bounded, escapes.escaped);
    $display("Covered %0d register writes, limits 0 to 65535, radii 0 to just under 4.0.",
             reg_writes);
    if (escapes.errors == 0) begin
      $display("PASS mandelbrot_escape_time");
    end else begin
      $display("FAIL mandelbrot_escape_time");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(CLK_PERIOD * 20_000_000);
    $display("FAIL mandelbrot_escape_time");
    $finish;
  end

endmodule

/* files.f */
src/mbe_pkg.sv
src/mbe_queue.sv
src/mbe_front.sv
src/mbe_back.sv
src/mandelbrot_escape_time.sv
tb/sv/mbe_scoreboard_pkg.sv
tb/sv/tb_top.sv
